[hdl/tlsf_pkg.sv]
package tlsf_pkg;

   // Binning geometry.
   localparam int SL_LOG2      = 4;
   localparam int GRANULE_LOG2 = 4;
   localparam int FL_MAX       = 24;
   localparam int COUNT_BITS   = 16;

   localparam int SL_COUNT    = 1 << SL_LOG2;
   localparam int LEVEL_SHIFT = SL_LOG2 + GRANULE_LOG2;
   localparam int BIN_TOTAL   = FL_MAX * SL_COUNT;

   // Field widths on the ports.
   localparam int CMD_W    = 2;
   localparam int SIZE_W   = 31;
   localparam int STATUS_W = 2;
   localparam int FL_OUT_W = 5;
   localparam int SL_OUT_W = 4;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;
   localparam int FLC_W      = 5;

   // Internal widths.
   localparam int NEED_W    = SIZE_W + 1;
   localparam int TOP_W     = $clog2(NEED_W);
   localparam int FL_IDX_W  = $clog2(FL_MAX);
   localparam int ADDR_W    = FL_IDX_W + SL_LOG2;
   localparam int CMP_W     = 8;

   localparam logic [NEED_W-1:0] SMALL_SIZE = NEED_W'(1) << LEVEL_SHIFT;
   localparam logic [NEED_W-1:0] GRAN_ADD   = NEED_W'((1 << GRANULE_LOG2) - 1);
   localparam logic [NEED_W-1:0] GRAN_MASK  = ~GRAN_ADD;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [CSR_DATA_W-1:0] MAX_REQ_RESET = CSR_DATA_W'(1048576);
   localparam logic [FLC_W-1:0]      FLC_RESET     = FLC_W'(24);

   // Commands.
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVER      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_BIN    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_COUNT_ERR = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MAX_REQUEST = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FL_COUNT    = 1'd1;

   // Index of the highest set bit.
   function automatic logic [TOP_W-1:0] top_bit(input logic [NEED_W-1:0] x);
      logic [TOP_W-1:0] r;
      r = '0;
      for (int i = 0; i < NEED_W; i++) begin
         if (x[i]) r = TOP_W'(i);
      end
      return r;
   endfunction

   // Index of the lowest set bit of a second-level map.
   function automatic logic [SL_LOG2-1:0] low_bit_sl(input logic [SL_COUNT-1:0] x);
      logic [SL_LOG2-1:0] r;
      r = '0;
      for (int i = SL_COUNT - 1; i >= 0; i--) begin
         if (x[i]) r = SL_LOG2'(i);
      end
      return r;
   endfunction

   // Index of the lowest set bit of the first-level map.
   function automatic logic [FL_IDX_W-1:0] low_bit_fl(input logic [FL_MAX-1:0] x);
      logic [FL_IDX_W-1:0] r;
      r = '0;
      for (int i = FL_MAX - 1; i >= 0; i--) begin
         if (x[i]) r = FL_IDX_W'(i);
      end
      return r;
   endfunction

endpackage

[hdl/tlsf_req_if.sv]
interface tlsf_req_if;
   import tlsf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [SIZE_W-1:0] size_bytes;

   modport source (output valid, command, size_bytes, input ready);
   modport sink (input valid, command, size_bytes, output ready);
endinterface

[hdl/tlsf_rsp_if.sv]
interface tlsf_rsp_if;
   import tlsf_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FL_OUT_W-1:0] first_level;
   logic [SL_OUT_W-1:0] second_level;

   modport source (output valid, status, first_level, second_level, input ready);
   modport sink (input valid, status, first_level, second_level, output ready);
endinterface

[hdl/tlsf_free_bin_index_top.sv]
// Bin index of a two-level segregated-fit allocator. Each request beat carries a
// command (find and take, insert, remove) and a size, and produces exactly one
// response beat with a status and the bin (first level, second level) used. Items
// are handled one at a time, each through granule rounding, bin rounding, binning
// and the bin check with the bitmap search. A refused request, a bin beyond the
// levels in use, a find with no free bin or an unused command then goes straight
// to the output step. Otherwise the bin count is read from the count memory,
// which has a registered read port, and written back in the update step. A find
// whose search moves to a higher first level first passes a step that picks the
// lowest bin of that level. The output step waits for as long as an earlier
// response still sits untaken in the response register. The next request beat
// can be accepted in the cycle after the output step. A new request beat is
// accepted while an earlier response still waits to be taken. The per-bin counts
// live in a memory that needs no clearing after reset: a count is only trusted
// while its bin's bit in the second-level map is set. Configuration writes are
// taken in any cycle and must only be made while idle.
module tlsf_free_bin_index_top (
   input  logic                              clock,
   input  logic                              reset,
   tlsf_req_if.sink                          req_ch,
   tlsf_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [tlsf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tlsf_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import tlsf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_UP,
      S_BIN,
      S_LOOK,
      S_LEVEL2,
      S_MOD,
      S_OUT
   } state_type;

   // Registers.
   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic                  over_ff, over_in;
   logic [NEED_W-1:0]     src_ff, src_in;
   logic [TOP_W-1:0]      bin_f_ff, bin_f_in;
   logic [SL_LOG2-1:0]    bin_s_ff, bin_s_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [TOP_W-1:0]      res_fl_ff, res_fl_in;
   logic [SL_LOG2-1:0]    res_sl_ff, res_sl_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [TOP_W-1:0]      rsp_fl_ff, rsp_fl_in;
   logic [SL_LOG2-1:0]    rsp_sl_ff, rsp_sl_in;
   logic [CSR_DATA_W-1:0] max_req_ff, max_req_in;
   logic [FLC_W-1:0]      fl_count_ff, fl_count_in;
   logic [FL_MAX-1:0]     l1_ff, l1_in;
   logic [SL_COUNT-1:0]   maps_ff [FL_MAX];

   // Bin count memory.
   logic [COUNT_BITS-1:0] count_mem [BIN_TOTAL];
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic                  mem_re;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   // Working signals.
   logic [CMP_W-1:0]      levels;
   logic [FL_IDX_W-1:0]   row_idx;
   logic                  row_in_range;
   logic [SL_COUNT-1:0]   row;
   logic [SL_COUNT-1:0]   smap;
   logic [FL_MAX-1:0]     fmap;
   logic                  row_we;
   logic [SL_COUNT-1:0]   row_wdata;
   logic [TOP_W-1:0]      need_top;
   logic [NEED_W-1:0]     up_add;
   logic [TOP_W-1:0]      src_top;
   logic [SL_COUNT-1:0]   bin_bit;
   logic [COUNT_BITS-1:0] cur_count;
   logic [FL_MAX-1:0]     l1_check;

   // Levels in use, clamped to the number of first levels built.
   assign levels = (CMP_W'(fl_count_ff) > CMP_W'(FL_MAX)) ? CMP_W'(FL_MAX)
                                                          : CMP_W'(fl_count_ff);

   // One read of the second-level maps, at the current first level.
   assign row_idx      = bin_f_ff[FL_IDX_W-1:0];
   assign row_in_range = (CMP_W'(bin_f_ff) < CMP_W'(FL_MAX));
   assign row          = row_in_range ? maps_ff[row_idx] : '0;
   assign smap         = row & ({SL_COUNT{1'b1}} << bin_s_ff);
   assign bin_bit      = SL_COUNT'(1) << bin_s_ff;

   // Higher first levels in use that still hold a free bin.
   always_comb begin
      for (int j = 0; j < FL_MAX; j++) begin
         fmap[j] = l1_ff[j] && (CMP_W'(j) > CMP_W'(bin_f_ff)) && (CMP_W'(j) < levels);
      end
   end

   // Size rounding and binning helpers.
   assign need_top  = top_bit(need_ff);
   assign up_add    = (NEED_W'(1) << (need_top - TOP_W'(SL_LOG2))) - NEED_W'(1);
   assign src_top   = top_bit(src_ff);

   // A count is valid only while its map bit is set.
   assign cur_count = (row & bin_bit) != '0 ? count_rd_ff : '0;

   // Next-state and datapath logic.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      need_in       = need_ff;
      over_in       = over_ff;
      src_in        = src_ff;
      bin_f_in      = bin_f_ff;
      bin_s_in      = bin_s_ff;
      res_status_in = res_status_ff;
      res_fl_in     = res_fl_ff;
      res_sl_in     = res_sl_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fl_in     = rsp_fl_ff;
      rsp_sl_in     = rsp_sl_ff;
      l1_in         = l1_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_raddr     = {row_idx, bin_s_ff};
      mem_waddr     = {row_idx, bin_s_ff};
      mem_wdata     = cur_count;
      row_we        = 1'b0;
      row_wdata     = row;

      // The response register empties when its beat is taken.
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               size_in  = req_ch.size_bytes;
               state_in = S_ROUND;
            end
         end

         // Round up to the granule and check the limit.
         S_ROUND: begin
            need_in  = ({1'b0, size_ff} + GRAN_ADD) & GRAN_MASK;
            over_in  = need_in > {1'b0, max_req_ff};
            state_in = S_UP;
         end

         // A find rounds up further to the next bin boundary.
         S_UP: begin
            if (cmd_ff == CMD_FIND) begin
               src_in = (need_ff >= SMALL_SIZE) ? need_ff + up_add : need_ff;
            end else begin
               src_in = {1'b0, size_ff};
            end
            state_in = S_BIN;
         end

         // Map the size to a bin.
         S_BIN: begin
            if (src_ff < SMALL_SIZE) begin
               bin_f_in = '0;
               bin_s_in = src_ff[LEVEL_SHIFT-1 -: SL_LOG2];
            end else begin
               bin_s_in = SL_LOG2'(src_ff >> (src_top - TOP_W'(SL_LOG2)));
               bin_f_in = src_top - TOP_W'(LEVEL_SHIFT - 1);
            end
            state_in = S_LOOK;
         end

         // Check the bin against the levels in use and search the maps.
         S_LOOK: begin
            case (cmd_ff)
               CMD_FIND: begin
                  res_fl_in = '0;
                  res_sl_in = '0;
                  if (over_ff) begin
                     res_status_in = ST_OVER;
                     state_in      = S_OUT;
                  end else if (CMP_W'(bin_f_ff) >= levels) begin
                     res_status_in = ST_NO_BIN;
                     state_in      = S_OUT;
                  end else if (smap != '0) begin
                     bin_s_in  = low_bit_sl(smap);
                     mem_re    = 1'b1;
                     mem_raddr = {row_idx, low_bit_sl(smap)};
                     state_in  = S_MOD;
                  end else if (fmap == '0) begin
                     res_status_in = ST_NO_BIN;
                     state_in      = S_OUT;
                  end else begin
                     bin_f_in = TOP_W'(low_bit_fl(fmap));
                     state_in = S_LEVEL2;
                  end
               end
               CMD_INSERT, CMD_REMOVE: begin
                  if (CMP_W'(bin_f_ff) >= levels) begin
                     res_status_in = ST_COUNT_ERR;
                     res_fl_in     = bin_f_ff;
                     res_sl_in     = bin_s_ff;
                     state_in      = S_OUT;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = S_MOD;
                  end
               end
               default: begin
                  res_status_in = ST_OK;
                  res_fl_in     = '0;
                  res_sl_in     = '0;
                  state_in      = S_OUT;
               end
            endcase
         end

         // Lowest bin of the higher first level found.
         S_LEVEL2: begin
            bin_s_in  = low_bit_sl(row);
            mem_re    = 1'b1;
            mem_raddr = {row_idx, low_bit_sl(row)};
            state_in  = S_MOD;
         end

         // Update the count and the bitmaps.
         S_MOD: begin
            res_fl_in     = bin_f_ff;
            res_sl_in     = bin_s_ff;
            res_status_in = ST_OK;
            if (cmd_ff == CMD_INSERT) begin
               if (cur_count == COUNT_MAX) begin
                  res_status_in = ST_COUNT_ERR;
               end else begin
                  mem_we            = 1'b1;
                  mem_wdata         = cur_count + COUNT_BITS'(1);
                  row_we            = 1'b1;
                  row_wdata         = row | bin_bit;
                  l1_in[row_idx]    = 1'b1;
               end
            end else begin
               if (cur_count == '0) begin
                  res_status_in = ST_COUNT_ERR;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = cur_count - COUNT_BITS'(1);
                  if (cur_count == COUNT_BITS'(1)) begin
                     row_we    = 1'b1;
                     row_wdata = row & ~bin_bit;
                     if ((row & ~bin_bit) == '0) begin
                        l1_in[row_idx] = 1'b0;
                     end
                  end
               end
            end
            state_in = S_OUT;
         end

         // Hand the result to the response register once it is free.
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fl_in     = res_fl_ff;
               rsp_sl_in     = res_sl_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      max_req_in  = max_req_ff;
      fl_count_in = fl_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MAX_REQUEST: max_req_in  = csr_wr_data;
            REG_FL_COUNT:    fl_count_in = csr_wr_data[FLC_W-1:0];
            default:         max_req_in  = max_req_ff;
         endcase
      end
   end

   // State, maps and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         max_req_ff   <= MAX_REQ_RESET;
         fl_count_ff  <= FLC_RESET;
         l1_ff        <= '0;
         for (int i = 0; i < FL_MAX; i++) begin
            maps_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_req_ff   <= max_req_in;
         fl_count_ff  <= fl_count_in;
         l1_ff        <= l1_in;
         if (row_we) begin
            maps_ff[row_idx] <= row_wdata;
         end
      end
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      need_ff       <= need_in;
      over_ff       <= over_in;
      src_ff        <= src_in;
      bin_f_ff      <= bin_f_in;
      bin_s_ff      <= bin_s_in;
      res_status_ff <= res_status_in;
      res_fl_ff     <= res_fl_in;
      res_sl_ff     <= res_sl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fl_ff     <= rsp_fl_in;
      rsp_sl_ff     <= rsp_sl_in;
   end

   // Count memory with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         count_rd_ff <= count_mem[mem_raddr];
      end
   end

   // Port connections.
   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.first_level  = FL_OUT_W'(rsp_fl_ff);
   assign rsp_ch.second_level = SL_OUT_W'(rsp_sl_ff);

   // The first-level map mirrors which second-level maps are non-empty.
   always_comb begin
      for (int f = 0; f < FL_MAX; f++) begin
         l1_check[f] = (maps_ff[f] != '0);
      end
   end

   a_l1_matches_maps: assert property (@(posedge clock) disable iff (reset)
      l1_ff == l1_check)
      else $error("first-level map out of step with second-level maps");

   a_find_bin_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD && cmd_ff == CMD_FIND) |-> ((row & bin_bit) != '0))
      else $error("find selected an empty bin");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response loaded outside the output step");

   a_over_zero_bin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_OVER || rsp_status_ff == ST_NO_BIN))
      |-> (rsp_fl_ff == '0 && rsp_sl_ff == '0))
      else $error("refused request reports a nonzero bin");

   a_count_write_in_mod: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_MOD && row_in_range))
      else $error("count written outside the update step");

endmodule

[tb/tlsf_free_bin_index_top_tb.sv]
module tlsf_free_bin_index_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tlsf_pkg::*;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 20000;
   localparam int STACK_DEPTH     = 8;

   localparam logic [CMD_W-1:0]      CMD_UNUSED    = 2'd3;
   localparam logic [SIZE_W-1:0]     SIZE_TOP      = 31'h7FFF_FFFF;
   // Lands in the top bin: first level 23, second level 15.
   localparam logic [SIZE_W-1:0]     TOP_BIN_SIZE  = 31'h7C00_0000;
   localparam logic [CSR_DATA_W-1:0] REQUEST_TOP   = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FL_OUT_W-1:0] first_level;
      logic [SL_OUT_W-1:0] second_level;
   } bin_result_type;

   // Tracks the bitmaps and bin counts, and holds the responses still owed.
   class bin_index_scoreboard;
      logic [CSR_DATA_W-1:0] max_request;
      logic [FLC_W-1:0]      level_limit;
      logic [FL_MAX-1:0]     level_map;
      logic [SL_COUNT-1:0]   slice_maps [FL_MAX];
      int unsigned           free_count [BIN_TOTAL];
      bin_result_type        owed [$];
      int                    mismatches;
      int                    checked;
      int                    status_seen [4];

      function new();
         max_request = MAX_REQ_RESET;
         level_limit = FLC_RESET;
         level_map   = '0;
         foreach (slice_maps[i]) slice_maps[i] = '0;
         foreach (free_count[i]) free_count[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] index,
                              input logic [CSR_DATA_W-1:0] data);
         if (index == REG_MAX_REQUEST) max_request = data;
         else if (index == REG_FL_COUNT) level_limit = data[FLC_W-1:0];
      endfunction

      function int msb_index(input longint unsigned x);
         int r;
         r = 0;
         for (int i = 0; i < 64; i++) if (x[i]) r = i;
         return r;
      endfunction

      function int lsb_index(input longint unsigned x);
         int r;
         r = 0;
         for (int i = 63; i >= 0; i--) if (x[i]) r = i;
         return r;
      endfunction

      // Sizes below the small limit map linearly into level zero; larger ones
      // take the top set bit as the level and the bits below it as the slice.
      function void size_to_bin(input longint unsigned amount, output int fl, output int sl);
         int m;
         if (amount < (64'd1 << LEVEL_SHIFT)) begin
            fl = 0;
            sl = int'((amount >> GRANULE_LOG2) & (SL_COUNT - 1));
         end else begin
            m  = msb_index(amount);
            sl = int'((amount >> (m - SL_LOG2)) & (SL_COUNT - 1));
            fl = m - LEVEL_SHIFT + 1;
         end
      endfunction

      function void take_block(input int fl, input int sl);
         int slot;
         slot = fl * SL_COUNT + sl;
         free_count[slot]--;
         if (free_count[slot] == 0) begin
            slice_maps[fl][sl] = 1'b0;
            if (slice_maps[fl] == '0) level_map[fl] = 1'b0;
         end
      endfunction

      // Works out the response to an accepted request beat and queues it.
      function void note_request(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size);
         bin_result_type      r;
         longint unsigned     need;
         int                  levels;
         int                  fl;
         int                  sl;
         int                  slot;
         logic [SL_COUNT-1:0] slice_hits;
         logic [FL_MAX-1:0]   level_hits;
         r      = '0;
         r.status = ST_OK;
         levels = (level_limit > FL_MAX) ? FL_MAX : int'(level_limit);
         case (cmd)
            CMD_FIND: begin
               need = ((longint'(size) + (1 << GRANULE_LOG2) - 1) >> GRANULE_LOG2)
                      << GRANULE_LOG2;
               if (need > max_request) begin
                  r.status = ST_OVER;
               end else begin
                  // Round up to the next bin boundary so any block found fits.
                  if (need >= (64'd1 << LEVEL_SHIFT))
                     need += (64'd1 << (msb_index(need) - SL_LOG2)) - 1;
                  size_to_bin(need, fl, sl);
                  if (fl >= levels) begin
                     r.status = ST_NO_BIN;
                  end else begin
                     slice_hits = slice_maps[fl] & ({SL_COUNT{1'b1}} << sl);
                     if (slice_hits == '0) begin
                        level_hits = level_map & ~({FL_MAX{1'b1}} << levels)
                                     & ({FL_MAX{1'b1}} << (fl + 1));
                        if (level_hits == '0) begin
                           r.status = ST_NO_BIN;
                        end else begin
                           fl         = lsb_index(level_hits);
                           slice_hits = slice_maps[fl];
                        end
                     end
                     if (r.status == ST_OK && slice_hits != '0) begin
                        sl = lsb_index(slice_hits);
                        take_block(fl, sl);
                        r.first_level  = FL_OUT_W'(fl);
                        r.second_level = SL_OUT_W'(sl);
                     end else begin
                        r.status = ST_NO_BIN;
                     end
                  end
               end
            end
            CMD_INSERT, CMD_REMOVE: begin
               size_to_bin(longint'(size), fl, sl);
               r.first_level  = FL_OUT_W'(fl);
               r.second_level = SL_OUT_W'(sl);
               slot = fl * SL_COUNT + sl;
               if (fl >= levels) begin
                  r.status = ST_COUNT_ERR;
               end else if (cmd == CMD_INSERT) begin
                  if (free_count[slot] >= (1 << COUNT_BITS) - 1) begin
                     r.status = ST_COUNT_ERR;
                  end else begin
                     free_count[slot]++;
                     slice_maps[fl][sl] = 1'b1;
                     level_map[fl]      = 1'b1;
                  end
               end else if (free_count[slot] == 0) begin
                  r.status = ST_COUNT_ERR;
               end else begin
                  take_block(fl, sl);
               end
            end
            default: ;
         endcase
         owed.push_back(r);
      endfunction

      // Compares a response beat against the oldest owed result.
      function void check_response(input logic [STATUS_W-1:0] status,
                                   input logic [FL_OUT_W-1:0] first_level,
                                   input logic [SL_OUT_W-1:0] second_level);
         bin_result_type want;
         if (owed.size() == 0) begin
            $error("response beat with no request outstanding: status %0d level %0d/%0d",
                   status, first_level, second_level);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         checked++;
         status_seen[want.status]++;
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (first_level !== want.first_level) begin
            $error("first_level: expected %0d, actual %0d", want.first_level, first_level);
            mismatches++;
         end
         if (second_level !== want.second_level) begin
            $error("second_level: expected %0d, actual %0d", want.second_level, second_level);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   tlsf_req_if req_bus ();
   tlsf_rsp_if rsp_bus ();

   bin_index_scoreboard sb = new();

   bit                idle_on = 1'b1;
   bit                hold_off_req = 1'b0;
   int                stuck_cycles = 0;
   logic [SIZE_W-1:0] live_sizes [$];

   tlsf_free_bin_index_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus.sink),
      .rsp_ch      (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Beats are sampled mid-cycle, away from the edges where they are driven.
   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.status, rsp_bus.first_level, rsp_bus.second_level);
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.command, req_bus.size_bytes);
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles.", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(99) < 23);
         end
      end
   end

   // Offers one request beat and returns at the edge that accepts it.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size);
      while (idle_on && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.size_bytes <= size;
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Stops offering and waits for every owed response, plus a margin.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers on back-to-back edges; only called while idle.
   task automatic configure(input logic [CSR_DATA_W-1:0] max_request,
                            input logic [FLC_W-1:0] level_count);
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_MAX_REQUEST;
      csr_wr_data <= max_request;
      @(posedge clock);
      sb.write_reg(REG_MAX_REQUEST, max_request);
      csr_index   <= REG_FL_COUNT;
      csr_wr_data <= CSR_DATA_W'(level_count);
      @(posedge clock);
      sb.write_reg(REG_FL_COUNT, CSR_DATA_W'(level_count));
      csr_wr_en <= 1'b0;
   endtask

   // Roughly log-uniform sizes, mostly in the range the default levels cover.
   function automatic logic [SIZE_W-1:0] rand_size();
      int k;
      k = ($urandom_range(99) < 80) ? $urandom_range(3, 22) : $urandom_range(0, SIZE_W - 1);
      return (SIZE_W'($urandom) & ((SIZE_W'(1) << k) - SIZE_W'(1))) | (SIZE_W'(1) << k);
   endfunction

   // Mostly allocator-like traffic: inserts, finds, and removes of blocks that
   // were inserted earlier, with a little noise mixed in.
   task automatic run_traffic(input int count, input bit with_hold_off);
      int                roll;
      int                pick;
      logic [CMD_W-1:0]  cmd;
      logic [SIZE_W-1:0] size;
      for (int n = 0; n < count; n++) begin
         if (with_hold_off && n == count / 3) hold_off_req = 1'b1;
         roll = $urandom_range(99);
         if (roll < 40) begin
            cmd  = CMD_INSERT;
            size = rand_size();
            if (live_sizes.size() < 96) live_sizes.push_back(size);
         end else if (roll < 75) begin
            cmd  = CMD_FIND;
            size = rand_size();
         end else if (roll < 95 && live_sizes.size() > 0) begin
            pick = $urandom_range(live_sizes.size() - 1);
            cmd  = CMD_REMOVE;
            size = live_sizes[pick];
            live_sizes.delete(pick);
         end else begin
            cmd  = $urandom_range(1) ? CMD_REMOVE : CMD_UNUSED;
            size = SIZE_W'($urandom);
         end
         send_item(cmd, size);
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_FIND;
      req_bus.size_bytes <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= REG_MAX_REQUEST;
      csr_wr_data        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: empty search, zero size, level-zero slices, promotion
      // to a higher level, the top level, the request limit and the unused command.
      send_item(CMD_FIND, 1);
      send_item(CMD_INSERT, 0);
      send_item(CMD_INSERT, 1);
      send_item(CMD_FIND, 0);
      send_item(CMD_REMOVE, 15);
      send_item(CMD_REMOVE, 16);
      send_item(CMD_INSERT, 255);
      send_item(CMD_INSERT, 256);
      send_item(CMD_FIND, 2);
      send_item(CMD_FIND, 200);
      send_item(CMD_INSERT, SIZE_TOP);
      send_item(CMD_FIND, 1048576);
      send_item(CMD_FIND, 1048577);
      send_item(CMD_UNUSED, SIZE_TOP);
      send_item(CMD_INSERT, 31'h4000_0000);
      drain();

      // One level in use and the widest limit: bins beyond the levels in use,
      // and a search that must not see the upper levels.
      configure(REQUEST_TOP, 1);
      send_item(CMD_INSERT, 256);
      send_item(CMD_REMOVE, SIZE_TOP);
      send_item(CMD_FIND, SIZE_TOP);
      send_item(CMD_FIND, 31'h7FFF_FFF0);
      send_item(CMD_FIND, 1);
      drain();

      // A request limit of 1, and a level count above the number of levels.
      configure(1, 31);
      send_item(CMD_FIND, 1);
      send_item(CMD_FIND, 0);
      send_item(CMD_INSERT, SIZE_TOP);
      send_item(CMD_REMOVE, SIZE_TOP);
      drain();

      // Stack blocks in the top bin back to back, then remove more than it
      // holds so that it runs empty and the last removes hit an empty bin.
      configure(MAX_REQ_RESET, FLC_RESET);
      idle_on = 1'b0;
      for (int n = 0; n < STACK_DEPTH; n++) send_item(CMD_INSERT, TOP_BIN_SIZE);
      for (int n = 0; n < STACK_DEPTH + 2; n++) send_item(CMD_REMOVE, TOP_BIN_SIZE);
      drain();
      idle_on = 1'b1;

      // Random traffic over several settings.
      configure(MAX_REQ_RESET, FLC_RESET);
      run_traffic(250, 1'b1);
      drain();

      idle_on = 1'b0;
      configure(REQUEST_TOP, FLC_RESET);
      run_traffic(250, 1'b0);
      drain();
      idle_on = 1'b1;

      configure(CSR_DATA_W'($urandom_range(16, 65536)), FLC_W'($urandom_range(1, 23)));
      run_traffic(250, 1'b0);
      drain();

      configure(CSR_DATA_W'($urandom_range(1, 32'h7FFF_FFFF)), 31);
      run_traffic(250, 1'b0);
      drain();

      configure(4096, 1);
      run_traffic(150, 1'b0);
      drain();

      $display("Checked %0d responses: %0d ok, %0d over limit, %0d no bin, %0d count errors.",
               sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_OVER],
               sb.status_seen[ST_NO_BIN], sb.status_seen[ST_COUNT_ERR]);
      $display("Settings ranged over one to all levels and the full request limit range.");
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
